[src/three_way_alignment_cost_scorer_core_macros.svh]
// Assertion macros used by the checker file of the alignment cost scorer.
`ifndef THREE_WAY_ALIGNMENT_COST_SCORER_CORE_MACROS_SVH
`define THREE_WAY_ALIGNMENT_COST_SCORER_CORE_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define TWACS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TWACS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[src/twacs_pkg.sv]
// Types, constants and helper functions of the alignment cost scorer.
package twacs_pkg;
	localparam int N_SEQ        = 3;
	localparam int CHAR_BITS_DEF = 8;
	localparam int KIND_W       = 2;
	localparam int CFG_W        = 8;
	localparam int COST_W       = 32;
	localparam int ADD_W        = 12;
	localparam int REG_IDX_W    = 2;
	localparam int CNT_W        = 2;

	localparam logic [REG_IDX_W-1:0] REG_MISMATCH   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAP_OPEN   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAP_EXTEND = 2'd2;

	localparam logic [CFG_W-1:0] MISMATCH_RST   = 8'd1;
	localparam logic [CFG_W-1:0] GAP_OPEN_RST   = 8'd3;
	localparam logic [CFG_W-1:0] GAP_EXTEND_RST = 8'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_MATCH  = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_INSERT = 2'd2
	} kind_t;

	typedef struct packed {
		logic is_match;
		logic is_del;
		logic is_ins;
		logic open;
		logic eq_next;
	} lane_res_t;

	// The unused code is scored as an insert.
	function automatic kind_t norm_kind(input logic [KIND_W-1:0] raw);
		kind_t k;
		case (raw)
			KIND_MATCH:  k = KIND_MATCH;
			KIND_DELETE: k = KIND_DELETE;
			default:     k = KIND_INSERT;
		endcase
		return k;
	endfunction
endpackage

[src/twacs_col_if.sv]
// Column input channel of the alignment cost scorer.
interface twacs_col_if import twacs_pkg::*; #(parameter int CHAR_BITS = CHAR_BITS_DEF) ();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind_a;
	logic [KIND_W-1:0]    kind_b;
	logic [KIND_W-1:0]    kind_c;
	logic [CHAR_BITS-1:0] char_a;
	logic [CHAR_BITS-1:0] char_b;
	logic [CHAR_BITS-1:0] char_c;
	logic                 last_column;

	modport source (output valid, kind_a, kind_b, kind_c, char_a, char_b, char_c,
		last_column, input ready);
	modport sink (input valid, kind_a, kind_b, kind_c, char_a, char_b, char_c,
		last_column, output ready);
endinterface

[src/twacs_res_if.sv]
// Result output channel of the alignment cost scorer.
interface twacs_res_if import twacs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COST_W-1:0] running_cost;
	logic              is_final;

	modport source (output valid, running_cost, is_final, input ready);
	modport sink (input valid, running_cost, is_final, output ready);
endinterface

[src/twacs_cfg_if.sv]
// Register write channel of the alignment cost scorer.
interface twacs_cfg_if import twacs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[src/twacs_lane.sv]
// One sequence lane: kind decode, gap-open detect and neighbor character compare.
module twacs_lane import twacs_pkg::*; #(
	parameter int CHAR_BITS = CHAR_BITS_DEF
) (
	input  logic [KIND_W-1:0]    kind_raw,
	input  kind_t                prev_kind,
	input  logic [CHAR_BITS-1:0] chr,
	input  logic [CHAR_BITS-1:0] chr_next,
	output kind_t                kind,
	output lane_res_t            lane
);
	always_comb begin
		kind          = norm_kind(kind_raw);
		lane.is_match = (kind == KIND_MATCH);
		lane.is_del   = (kind == KIND_DELETE);
		lane.is_ins   = (kind == KIND_INSERT);
		lane.open     = (kind != KIND_MATCH) && (kind != prev_kind);
		lane.eq_next  = (chr == chr_next);
	end
endmodule

[src/twacs_merge.sv]
// Merge stage: combines the lane results of one column into its cost increment.
module twacs_merge import twacs_pkg::*; (
	input  lane_res_t        lanes [N_SEQ],
	input  logic [CFG_W-1:0] subst_cost,
	input  logic [CFG_W-1:0] gap_open_cost,
	input  logic [CFG_W-1:0] gap_extend_cost,
	output logic [ADD_W-1:0] add
);
	logic [CNT_W-1:0] n_open;
	logic [CNT_W-1:0] n_del;
	logic [CNT_W-1:0] diffs;
	logic             any_ins;
	logic [2:0]       match_mask;
	logic             e01;
	logic             e12;
	logic             e20;
	logic [ADD_W-1:0] open_part;
	logic [ADD_W-1:0] ext_part;
	logic [ADD_W-1:0] mis_part;

	always_comb begin
		n_open     = CNT_W'(lanes[0].open) + CNT_W'(lanes[1].open) + CNT_W'(lanes[2].open);
		n_del      = CNT_W'(lanes[0].is_del) + CNT_W'(lanes[1].is_del)
			+ CNT_W'(lanes[2].is_del);
		any_ins    = lanes[0].is_ins | lanes[1].is_ins | lanes[2].is_ins;
		match_mask = {lanes[2].is_match, lanes[1].is_match, lanes[0].is_match};
		e01        = lanes[0].eq_next;
		e12        = lanes[1].eq_next;
		e20        = lanes[2].eq_next;

		case (match_mask)
			3'b111: begin
				if (e20 && !e01)
					diffs = CNT_W'(1);
				else
					diffs = CNT_W'(!e01) + CNT_W'(!e12);
			end
			3'b011:  diffs = CNT_W'(!e01);
			3'b110:  diffs = CNT_W'(!e12);
			3'b101:  diffs = CNT_W'(!e20);
			default: diffs = '0;
		endcase

		open_part = ADD_W'(gap_open_cost) * ADD_W'(n_open);
		if (any_ins) begin
			ext_part = ADD_W'(gap_extend_cost);
			mis_part = '0;
		end else begin
			ext_part = ADD_W'(gap_extend_cost) * ADD_W'(n_del);
			mis_part = ADD_W'(subst_cost) * ADD_W'(diffs);
		end
		add = open_part + ext_part + mis_part;
	end
endmodule

[src/three_way_alignment_cost_scorer_core.sv]
// Top level of the three-sequence alignment cost scorer.
// The col channel takes one alignment column per word: three kinds (match, delete,
// insert), three characters and a last-column flag. The res channel returns one word
// per column with the saturating running cost and a flag that marks the final total.
// The cfg channel writes the mismatch, gap-open and gap-extend costs; it is always
// ready and must only be used while no column is in flight.
// Three lanes decode the kinds and compare characters in the accept cycle, and the
// merge stage plus the accumulator turn the registered lane results into the result.
// Each column passes the lane stage register and then the output register. One column
// is taken every cycle while the receiver keeps up; the accumulator feedback around
// the merge stage sets that rate. When the receiver stalls, the output register holds
// its word and the lane stage fills; col.ready drops only when both are full.
// Reset clears the running cost, sets all previous kinds to match and loads the
// default costs (mismatch 1, gap open 3, gap extend 1). The state returns to its reset
// value after each final column; the cost registers keep their values.
module three_way_alignment_cost_scorer_core import twacs_pkg::*; #(
	parameter int CHAR_BITS = CHAR_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	twacs_col_if.sink   col,
	twacs_res_if.source res,
	twacs_cfg_if.sink   cfg
);
	logic [CFG_W-1:0] subst_cost_q;
	logic [CFG_W-1:0] gap_open_cost_q;
	logic [CFG_W-1:0] gap_extend_cost_q;

	kind_t                prev_kind_q [N_SEQ];
	logic [KIND_W-1:0]    kind_raw    [N_SEQ];
	logic [CHAR_BITS-1:0] chr         [N_SEQ];
	kind_t                kind        [N_SEQ];
	lane_res_t            lane        [N_SEQ];

	lane_res_t         lanes_s1 [N_SEQ];
	logic              last_s1;
	logic              valid_s1;
	logic [ADD_W-1:0]  add;
	logic [COST_W-1:0] cost_q;
	logic [COST_W:0]   sum;
	logic [COST_W-1:0] sat;
	logic              res_valid_q;
	logic [COST_W-1:0] res_cost_q;
	logic              res_final_q;
	logic              out_ld;
	logic              s1_adv;
	logic              col_acc;

	assign kind_raw[0] = col.kind_a;
	assign kind_raw[1] = col.kind_b;
	assign kind_raw[2] = col.kind_c;
	assign chr[0]      = col.char_a;
	assign chr[1]      = col.char_b;
	assign chr[2]      = col.char_c;

	for (genvar i = 0; i < N_SEQ; i++) begin : g_lane
		twacs_lane #(.CHAR_BITS(CHAR_BITS)) u_lane (
			.kind_raw  (kind_raw[i]),
			.prev_kind (prev_kind_q[i]),
			.chr       (chr[i]),
			.chr_next  (chr[(i + 1) % N_SEQ]),
			.kind      (kind[i]),
			.lane      (lane[i])
		);
	end

	twacs_merge u_merge (
		.lanes           (lanes_s1),
		.subst_cost      (subst_cost_q),
		.gap_open_cost   (gap_open_cost_q),
		.gap_extend_cost (gap_extend_cost_q),
		.add             (add)
	);

	assign out_ld    = !res_valid_q || res.ready;
	assign s1_adv    = valid_s1 && out_ld;
	assign col.ready = !valid_s1 || out_ld;
	assign col_acc   = col.valid && col.ready;
	assign cfg.ready = 1'b1;

	assign sum = {1'b0, cost_q} + (COST_W + 1)'(add);
	assign sat = sum[COST_W] ? '1 : sum[COST_W-1:0];

	assign res.valid        = res_valid_q;
	assign res.running_cost = res_cost_q;
	assign res.is_final     = res_final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subst_cost_q      <= MISMATCH_RST;
			gap_open_cost_q   <= GAP_OPEN_RST;
			gap_extend_cost_q <= GAP_EXTEND_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MISMATCH:   subst_cost_q      <= cfg.data;
				REG_GAP_OPEN:   gap_open_cost_q   <= cfg.data;
				REG_GAP_EXTEND: gap_extend_cost_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_SEQ; i++)
				prev_kind_q[i] <= KIND_MATCH;
			valid_s1    <= 1'b0;
			cost_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (col_acc) begin
				for (int i = 0; i < N_SEQ; i++)
					prev_kind_q[i] <= col.last_column ? KIND_MATCH : kind[i];
			end
			if (col_acc)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
			if (s1_adv)
				cost_q <= last_s1 ? '0 : sat;
			if (out_ld)
				res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (col_acc) begin
			lanes_s1 <= lane;
			last_s1  <= col.last_column;
		end
		if (s1_adv) begin
			res_cost_q  <= sat;
			res_final_q <= last_s1;
		end
	end
endmodule

[src/twacs_checker.sv]
// Port-level checker of the alignment cost scorer and its bind to the top level.
`include "three_way_alignment_cost_scorer_core_macros.svh"

module twacs_checker import twacs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              col_valid,
	input logic              col_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [COST_W-1:0] res_cost,
	input logic              res_final
);
	logic [CNT_W-1:0]  outstanding_q;
	logic [COST_W-1:0] last_cost_q;
	logic              open_q;
	logic              col_acc;
	logic              res_acc;

	assign col_acc = col_valid && col_ready;
	assign res_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			open_q        <= 1'b0;
		end else begin
			outstanding_q <= outstanding_q + CNT_W'(col_acc) - CNT_W'(res_acc);
			if (res_acc)
				open_q <= !res_final;
		end
	end

	always_ff @(posedge clk) begin
		if (res_acc)
			last_cost_q <= res_cost;
	end

	`TWACS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable(res_cost) && $stable(res_final),
		"Result word changed while stalled.")
	`TWACS_ASSERT_NOW(a_res_has_source, res_valid, outstanding_q != '0,
		"Result word without an accepted column.")
	`TWACS_ASSERT_NOW(a_cost_monotone, res_acc && open_q, res_cost >= last_cost_q,
		"Running cost decreased within an alignment.")
	`TWACS_ASSERT_NOW(a_cost_sticks, res_acc && open_q && (last_cost_q == '1),
		res_cost == '1, "Saturated running cost did not stick.")
endmodule

bind three_way_alignment_cost_scorer_core twacs_checker u_twacs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.col_valid (col.valid),
	.col_ready (col.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_cost  (res.running_cost),
	.res_final (res.is_final)
);
